// ----- hdl/lisl_pkg.sv -----
// Shared types and constants of the longest increasing subsequence length unit.
package lisl_pkg;

	// Width of one sequence element.
	localparam int unsigned VALUE_W = 32;

	// Width of the reported length field.
	localparam int unsigned LENGTH_W = 11;

	// Width of the input stream data bus.
	localparam int unsigned IN_TDATA_W = 32;

	// Width of the output stream data bus (length padded to whole bytes).
	localparam int unsigned OUT_TDATA_W = 16;

	// Control flags that travel along the cell chain with each element.
	typedef struct packed {
		logic valid;  // A real element occupies this slot of the chain.
		logic last;   // The element closes its sequence.
		logic done;   // Some cell has already stored the element.
	} tok_ctl_t;

endpackage

// ----- hdl/lisl_cell.sv -----
// One cell of the chain: holds a single tail and passes each element on to its neighbor.
module lisl_cell #(
	parameter int unsigned LEN_W = 11
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  lisl_pkg::tok_ctl_t                    ctl_in,
	input  logic signed [lisl_pkg::VALUE_W-1:0]   key_in,
	input  logic        [LEN_W-1:0]               len_in,
	output lisl_pkg::tok_ctl_t                    ctl_out,
	output logic signed [lisl_pkg::VALUE_W-1:0]   key_out,
	output logic        [LEN_W-1:0]               len_out
);

	logic                                occ_q;
	logic signed [lisl_pkg::VALUE_W-1:0] tail_q;
	lisl_pkg::tok_ctl_t                  ctl_q;
	logic signed [lisl_pkg::VALUE_W-1:0] key_q;
	logic        [LEN_W-1:0]             len_q;

	logic seek;
	logic hit_append;
	logic hit_replace;
	logic wr;
	logic occ_next;

	// The element is still looking for its place. An empty cell takes it as a new
	// top tail; a filled cell takes it when its tail is not below the element.
	// Since tails rise strictly along the chain, the first such cell is the right one.
	assign seek        = ctl_in.valid && !ctl_in.done;
	assign hit_append  = seek && !occ_q;
	assign hit_replace = seek && occ_q && (tail_q >= key_in);
	assign wr          = hit_append || hit_replace;
	assign occ_next    = occ_q || hit_append;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			ctl_q <= '0;
		end else if (en) begin
			// The closing element empties the cell once it has been counted.
			if (ctl_in.valid && ctl_in.last) begin
				occ_q <= 1'b0;
			end else begin
				occ_q <= occ_next;
			end
			ctl_q.valid <= ctl_in.valid;
			ctl_q.last  <= ctl_in.last;
			ctl_q.done  <= ctl_in.done || wr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr) begin
				tail_q <= key_in;
			end
			key_q <= key_in;
			len_q <= len_in + LEN_W'(occ_next);
		end
	end

	assign ctl_out = ctl_q;
	assign key_out = key_q;
	assign len_out = len_q;

endmodule

// ----- hdl/lisl_out.sv -----
// Output register of the unit with the per-sequence overflow flag.
module lisl_out #(
	parameter int unsigned LEN_W = 11
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lisl_pkg::tok_ctl_t                   ctl_in,
	input  logic [LEN_W-1:0]                     len_in,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [lisl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast,
	output logic                                 m_axis_tuser
);

	logic                              valid_q;
	logic                              sticky_q;
	logic [lisl_pkg::LENGTH_W-1:0]     length_q;
	logic                              last_q;
	logic                              ovf_q;
	logic                              load;
	logic                              ovf_now;
	logic [LEN_W+lisl_pkg::LENGTH_W-1:0] len_ext;

	assign load    = !valid_q || m_axis_tready;
	// An element that no cell took was dropped because the table was full.
	assign ovf_now = sticky_q || !ctl_in.done;
	assign len_ext = {{lisl_pkg::LENGTH_W{1'b0}}, len_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			sticky_q <= 1'b0;
		end else if (load) begin
			valid_q <= ctl_in.valid;
			if (ctl_in.valid) begin
				sticky_q <= ovf_now && !ctl_in.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && ctl_in.valid) begin
			length_q <= len_ext[lisl_pkg::LENGTH_W-1:0];
			last_q   <= ctl_in.last;
			ovf_q    <= ovf_now;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(lisl_pkg::OUT_TDATA_W-lisl_pkg::LENGTH_W){1'b0}}, length_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = ovf_q;

endmodule

// ----- hdl/longest_increasing_subsequence_length_unit.sv -----
// Top level of the streaming longest strictly increasing subsequence length unit.
//
// The unit takes signed 32-bit elements on the input stream, tlast marking the final
// element of a sequence, and returns one transaction per element carrying the length
// of the longest strictly increasing subsequence seen so far in that sequence. The
// tails of the patience table live in a chain of MAX_LEN identical cells, one tail per
// cell, in rising order along the chain. Every element enters the first cell and moves
// one cell per cycle while the chain is not stalled; the first cell that is empty or
// holds a tail not below the element stores it, and the element keeps traveling to
// count the filled cells. The closing element empties each cell as it passes, so the
// next sequence starts clean. An element accepted while the table is full and larger
// than every tail is dropped, the length stays at MAX_LEN and the overflow flag in
// tuser stays set until the sequence closes. A new element is accepted in every cycle
// in which the chain shifts: the sustained rate is one transaction per clock while
// the output stream takes results. The element passes MAX_LEN cell registers, the
// first of them loading at the accepting edge, and then the output register. While a
// result waits at the output, the chain still advances whenever its end slot is empty.
module longest_increasing_subsequence_length_unit #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream. tdata bits from the lowest up: value[31:0].
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [lisl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                 s_axis_tlast,
	// Output stream. tdata bits from the lowest up: length[10:0], zero padding[15:11].
	// tuser bits from the lowest up: overflow[0]. tlast carries final_res.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [lisl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast,
	output logic                                 m_axis_tuser
);

	// Count width: the length can reach MAX_LEN itself.
	localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

	lisl_pkg::tok_ctl_t                  ctl  [0:MAX_LEN];
	logic signed [lisl_pkg::VALUE_W-1:0] key  [0:MAX_LEN];
	logic        [LEN_W-1:0]             len  [0:MAX_LEN];
	logic                                en;

	// The whole chain shifts together. It may shift when the output register can take
	// the element at the end of the chain, or when that end slot holds no element.
	assign en            = !m_axis_tvalid || m_axis_tready || !ctl[MAX_LEN].valid;
	assign s_axis_tready = en;

	// Head of the chain: an element enters exactly when the input transaction completes.
	assign ctl[0].valid = s_axis_tvalid;
	assign ctl[0].last  = s_axis_tlast;
	assign ctl[0].done  = 1'b0;
	assign key[0]       = $signed(s_axis_tdata[lisl_pkg::VALUE_W-1:0]);
	assign len[0]       = '0;

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		lisl_cell #(
			.LEN_W(LEN_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl[i]),
			.key_in (key[i]),
			.len_in (len[i]),
			.ctl_out(ctl[i+1]),
			.key_out(key[i+1]),
			.len_out(len[i+1])
		);
	end

	// The element at the end of the chain carries its final count; its key is no
	// longer needed there, so the output stage sees only control and length.
	lisl_out #(
		.LEN_W(LEN_W)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_in       (ctl[MAX_LEN]),
		.len_in       (len[MAX_LEN]),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ----- dv/lisl_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts and compares the results of the increasing subsequence length unit.
module lisl_checker #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	input  logic [lisl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // value[31:0]
	input  logic                                 s_axis_tlast,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [lisl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // length[10:0], pad[15:11]
	input  logic                                 m_axis_tlast,
	input  logic                                 m_axis_tuser,   // overflow[0]
	output int                                   mismatches,
	output int                                   outstanding
);

	typedef struct packed {
		logic [lisl_pkg::LENGTH_W-1:0] length;
		logic                          final_res;
		logic                          overflow;
	} lis_result_t;

	// Patience table: smallest tail for each subsequence length, in rising order.
	logic signed [lisl_pkg::VALUE_W-1:0] tail_tbl [MAX_LEN];
	int unsigned                         tail_count = 0;
	logic                                table_overflowed = 1'b0;

	lis_result_t expected_lengths[$];

	// Folds one element into the patience table and returns the result it causes.
	function automatic lis_result_t fold_element(input logic signed [31:0] v, input logic l);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lis_result_t r;
		if (tail_count == 0) begin
			tail_tbl[0] = v;
			tail_count  = 1;
		end else if (v > tail_tbl[tail_count-1]) begin
			if (tail_count < MAX_LEN) begin
				tail_tbl[tail_count] = v;
				tail_count++;
			end else begin
				table_overflowed = 1'b1;
			end
		end else begin
			// Replace the first tail that is not below the element.
			lo = 0;
			hi = tail_count;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (tail_tbl[mid] < v)
					lo = mid + 1;
				else
					hi = mid;
			end
			tail_tbl[lo] = v;
		end
		r.length    = tail_count[lisl_pkg::LENGTH_W-1:0];
		r.final_res = l;
		r.overflow  = table_overflowed;
		if (l) begin
			tail_count       = 0;
			table_overflowed = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		lis_result_t exp_r;
		if (!arst_n) begin
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_lengths.push_back(fold_element(s_axis_tdata, s_axis_tlast));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_lengths.size() == 0) begin
					$error("result transaction with no expectation waiting");
					mismatches++;
				end else begin
					exp_r = expected_lengths.pop_front();
					if (m_axis_tdata[lisl_pkg::LENGTH_W-1:0] !== exp_r.length) begin
						$error("length mismatch: expected %0d, actual %0d", exp_r.length,
							m_axis_tdata[lisl_pkg::LENGTH_W-1:0]);
						mismatches++;
					end
					if (m_axis_tlast !== exp_r.final_res) begin
						$error("final_res mismatch: expected %0b, actual %0b",
							exp_r.final_res, m_axis_tlast);
						mismatches++;
					end
					if (m_axis_tuser !== exp_r.overflow) begin
						$error("overflow mismatch: expected %0b, actual %0b",
							exp_r.overflow, m_axis_tuser);
						mismatches++;
					end
				end
			end
			outstanding = expected_lengths.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the testbench: stimulus, flow control and verdict for the subsequence length unit.
module testbench;

	localparam int unsigned MAX_LEN       = 1024;
	// Stretch for which the receiver holds off once, well past what the cell chain can absorb.
	localparam int unsigned LONG_HOLD     = 2500;
	localparam int unsigned HOLD_AT       = 300;
	localparam int unsigned OVF_AT        = 500;
	localparam int unsigned TOTAL_ITEMS   = 1900;
	// Past this many transactions neither side idles any more.
	localparam int unsigned CALM_AFTER    = 1700;
	localparam int unsigned STALL_LIMIT   = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	int          mismatches;
	int          outstanding;
	int unsigned items_sent = 0;
	int unsigned stalled_cycles = 0;
	bit          long_hold_done = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	longest_increasing_subsequence_length_unit #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser)
	);

	lisl_checker #(
		.MAX_LEN(MAX_LEN)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Offers one element and returns at the edge where the transaction completes. Now and
	// then the valid drops for a short random burst first.
	task automatic send_element(input logic [31:0] v, input logic l);
		int unsigned gap;
		if (items_sent < CALM_AFTER && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Picks an element for a sequence of the given flavor. Flavor 3 walks a rising path with
	// noise around the running base, so longer subsequences build up.
	function automatic logic [31:0] pick_value(input int unsigned flavor, inout int base);
		case (flavor)
			0: pick_value = $urandom;
			1: pick_value = int'($urandom_range(0, 16)) - 8;
			2: begin
				if ($urandom_range(0, 1) == 0)
					pick_value = 32'h8000_0000 + $urandom_range(0, 3);
				else
					pick_value = 32'h7FFF_FFFF - $urandom_range(0, 3);
			end
			default: begin
				base = base + int'($urandom_range(0, 60)) - 15;
				pick_value = base;
			end
		endcase
	endfunction

	// Receiver flow control: random hold-off bursts, one long hold once the chain has work in
	// it, and a steady ready near the end of the run.
	initial begin
		int unsigned gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!long_hold_done && items_sent >= HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end else if (items_sent < CALM_AFTER && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 7);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Watchdog: ends the run when no transaction completes on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int          base;
		int          top;
		int unsigned flavor;
		int unsigned seq_len;
		int unsigned rises;
		logic        ovf_done;
		ovf_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-element sequences at both extremes of the value range.
		send_element(32'h8000_0000, 1'b1);
		send_element(32'h7FFF_FFFF, 1'b1);
		// Extremes, an equal value that must not extend, and replacements around zero.
		send_element(32'h8000_0000, 1'b0);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'h0000_0000, 1'b0);
		send_element(32'hFFFF_FFFF, 1'b0);
		send_element(32'h0000_0001, 1'b0);
		send_element(32'h0000_0002, 1'b1);
		// A run of equal values keeps the length at one.
		send_element(32'd5, 1'b0);
		send_element(32'd5, 1'b0);
		send_element(32'd5, 1'b1);
		// Strictly falling values, down across zero.
		send_element(32'd3, 1'b0);
		send_element(32'd2, 1'b0);
		send_element(32'd1, 1'b0);
		send_element(32'd0, 1'b0);
		send_element(32'hFFFF_FFFF, 1'b1);
		// A dip in the middle of a rising run replaces the first tail.
		send_element(32'd1, 1'b0);
		send_element(32'd2, 1'b0);
		send_element(32'd3, 1'b0);
		send_element(32'd0, 1'b0);
		send_element(32'd4, 1'b1);

		while (items_sent < TOTAL_ITEMS) begin
			if (!ovf_done && items_sent >= OVF_AT) begin
				// One sequence long enough to fill the table and run past it. Every rise goes
				// above the running top, dips land at or below it, so the length grows by one per
				// rise and then saturates with the overflow flag set.
				top   = -2000000000;
				rises = 0;
				send_element(top, 1'b0);
				while (rises < MAX_LEN + 40) begin
					if ($urandom_range(0, 7) == 0) begin
						send_element(top - int'($urandom_range(0, 2000)), 1'b0);
					end else begin
						top = top + int'($urandom_range(1, 1000));
						rises++;
						send_element(top, 1'b0);
					end
				end
				send_element(top + 1, 1'b1);
				ovf_done = 1'b1;
			end else begin
				flavor  = $urandom_range(0, 3);
				seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 150)
				                                      : $urandom_range(1, 30);
				base    = $urandom;
				for (int unsigned i = 1; i <= seq_len; i++)
					send_element(pick_value(flavor, base), i == seq_len);
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (MAX_LEN + 16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
